@@ design/plt_pkg.sv @@
`default_nettype none
package plt_pkg;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_P,
        S_WAIT_P,
        S_MUL_K,
        S_WAIT_K,
        S_DIV,
        S_WAIT_D,
        S_MUL_V,
        S_WAIT_V,
        S_EMIT
    } plt_state_t;

    // position in the line grammar
    typedef enum logic [3:0] {
        PH_B,
        PH_C1,
        PH_SEQ,
        PH_CAM,
        PH_SGN,
        PH_POS,
        PH_VAL,
        PH_DONE,
        PH_ERR
    } plt_phase_t;

    typedef enum logic [2:0] {
        EV_VALID     = 3'd0,
        EV_INVALID   = 3'd1,
        EV_MALFORMED = 3'd2,
        EV_DUPLICATE = 3'd3,
        EV_OVERFLOW  = 3'd4
    } plt_event_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } plt_op_t;

    // register indexes
    localparam logic [2:0] CFG_POS_GAIN  = 3'd0;
    localparam logic [2:0] CFG_VEL_GAIN  = 3'd1;
    localparam logic [2:0] CFG_POS_LIMIT = 3'd2;
    localparam logic [2:0] CFG_IVL_MIN   = 3'd3;
    localparam logic [2:0] CFG_IVL_MAX   = 3'd4;

    // characters
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [3:0] MAX_DIGITS = 4'd10;

    // arithmetic unit widths
    localparam int AW   = 66;   // accumulator, signed
    localparam int MW   = 17;   // multiplier operand, unsigned
    localparam int DW   = 44;   // dividend magnitude
    localparam int DENW = 16;   // divisor
    localparam int GAIN_SHIFT = 16;

    localparam logic [MW-1:0] RATE_SCALE = 17'd1000;
    localparam logic signed [AW-1:0] DIFF_CLAMP = AW'(1) <<< 46;

    // parsed line handed from the parser to the sequencer
    typedef struct packed {
        logic        ok;
        logic [31:0] seq;
        logic [31:0] cam;
        logic        neg;
        logic        mag_over;
        logic [14:0] mag;
        logic        valid_over;
        logic        valid_bit;
    } plt_line_t;

    function automatic logic [31:0] sat32(input logic signed [AW-1:0] x);
        if ((&x[AW-1:31]) || !(|x[AW-1:31]))
            return x[31:0];
        else if (x[AW-1])
            return {1'b1, 31'b0};
        else
            return {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic [63:0] sat64(input logic signed [AW-1:0] x);
        if ((&x[AW-1:63]) || !(|x[AW-1:63]))
            return x[63:0];
        else if (x[AW-1])
            return {1'b1, 63'b0};
        else
            return {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] clamp46(input logic signed [AW-1:0] x);
        if ((&x[AW-1:46]) || !(|x[AW-1:46]))
            return x;
        else if (x[AW-1])
            return -DIFF_CLAMP;
        else
            return DIFF_CLAMP;
    endfunction

endpackage
`default_nettype wire

@@ design/plt_if.sv @@
`default_nettype none
// input channel: one received character and its time stamp
interface plt_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    modport source(output valid, rx_byte, now_ms, input ready);
    modport sink(input valid, rx_byte, now_ms, output ready);
endinterface

// output channel: one event word
interface plt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] frame_sequence;
    logic [31:0] camera_time_ms;
    logic signed [15:0] raw_position_mm;
    logic        frame_valid;
    logic signed [31:0] filtered_position_q16;
    logic signed [63:0] velocity_q16;
    logic [15:0] sample_interval_ms;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    modport source(output valid, event_kind, frame_sequence, camera_time_ms,
                   raw_position_mm, frame_valid, filtered_position_q16,
                   velocity_q16, sample_interval_ms, good_count, bad_count,
                   input ready);
    modport sink(input valid, event_kind, frame_sequence, camera_time_ms,
                 raw_position_mm, frame_valid, filtered_position_q16,
                 velocity_q16, sample_interval_ms, good_count, bad_count,
                 output ready);
endinterface
`default_nettype wire

@@ design/plt_parser.sv @@
`default_nettype none
// Streaming parser: checks the line grammar one character at a time
module plt_parser
    import plt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] rx_byte,
    input  wire logic       clear,
    output plt_line_t       line
);

    plt_phase_t  phase_reg, phase_next;
    logic [33:0] acc_reg, acc_next;
    logic [3:0]  ndig_reg, ndig_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] cam_reg, cam_next;
    logic        neg_reg, neg_next;
    logic        mag_over_reg, mag_over_next;
    logic [14:0] mag_reg, mag_next;

    logic        is_digit;
    logic        is_comma;
    logic [33:0] acc_mul;

    assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign is_comma = (rx_byte == CH_COMMA);
    // acc * 10 + digit; at most ten digits are held here, so no wrap
    assign acc_mul  = {acc_reg[30:0], 3'b0} + {acc_reg[32:0], 1'b0}
                    + {30'b0, rx_byte[3:0]};

    // grammar step
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        ndig_next     = ndig_reg;
        seq_next      = seq_reg;
        cam_next      = cam_reg;
        neg_next      = neg_reg;
        mag_over_next = mag_over_reg;
        mag_next      = mag_reg;
        if (clear)
        begin
            phase_next = PH_B;
            acc_next   = '0;
            ndig_next  = '0;
        end
        else if (byte_en)
        begin
            case (phase_reg)
                PH_B:
                begin
                    phase_next = (rx_byte == CH_B) ? PH_C1 : PH_ERR;
                end
                PH_C1:
                begin
                    phase_next = is_comma ? PH_SEQ : PH_ERR;
                    acc_next   = '0;
                    ndig_next  = '0;
                end
                PH_SGN:
                begin
                    neg_next  = (rx_byte == CH_MINUS);
                    acc_next  = '0;
                    ndig_next = '0;
                    if (rx_byte == CH_MINUS || rx_byte == CH_PLUS)
                        phase_next = PH_POS;
                    else if (is_digit)
                    begin
                        phase_next = PH_POS;
                        acc_next   = {30'b0, rx_byte[3:0]};
                        ndig_next  = 4'd1;
                    end
                    else
                        phase_next = PH_ERR;
                end
                PH_SEQ, PH_CAM, PH_POS, PH_VAL:
                begin
                    if (is_digit)
                    begin
                        if (ndig_reg == MAX_DIGITS)
                            phase_next = PH_ERR;
                        else
                        begin
                            acc_next  = acc_mul;
                            ndig_next = ndig_reg + 4'd1;
                        end
                    end
                    else if (ndig_reg == 4'd0)
                        phase_next = PH_ERR;
                    else if (phase_reg == PH_VAL)
                        phase_next = PH_DONE;   // trailing text is ignored
                    else if (!is_comma)
                        phase_next = PH_ERR;
                    else
                    begin
                        acc_next  = '0;
                        ndig_next = '0;
                        case (phase_reg)
                            PH_SEQ:
                            begin
                                seq_next   = acc_reg[31:0];
                                phase_next = (|acc_reg[33:32]) ? PH_ERR : PH_CAM;
                            end
                            PH_CAM:
                            begin
                                cam_next   = acc_reg[31:0];
                                phase_next = (|acc_reg[33:32]) ? PH_ERR : PH_SGN;
                            end
                            default:
                            begin
                                mag_over_next = |acc_reg[33:15];
                                mag_next      = acc_reg[14:0];
                                phase_next    = PH_VAL;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_B;
            acc_reg   <= '0;
            ndig_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ndig_reg  <= ndig_next;
        end
    end

    // field values
    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        cam_reg      <= cam_next;
        neg_reg      <= neg_next;
        mag_over_reg <= mag_over_next;
        mag_reg      <= mag_next;
    end

    assign line.ok         = (phase_reg == PH_VAL && ndig_reg != 4'd0) ||
                             (phase_reg == PH_DONE);
    assign line.seq        = seq_reg;
    assign line.cam        = cam_reg;
    assign line.neg        = neg_reg;
    assign line.mag_over   = mag_over_reg;
    assign line.mag        = mag_reg;
    assign line.valid_over = |acc_reg[33:1];
    assign line.valid_bit  = acc_reg[0];

endmodule
`default_nettype wire

@@ design/plt_muldiv.sv @@
`default_nettype none
// Shared shift-add multiplier and restoring divider, one bit per cycle
module plt_muldiv
    import plt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire plt_op_t              op,
    input  wire logic signed [AW-1:0] opa,
    input  wire logic [MW-1:0]        opb,
    output logic                      busy,
    output logic                      done,
    output logic signed [AW-1:0]      result
);

    localparam int CW = $clog2(DW);

    logic                busy_reg;
    logic                done_reg;
    plt_op_t             op_reg;
    logic [CW-1:0]       cnt_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] mcand_reg;
    logic [MW-1:0]       mplier_reg;
    logic [DENW:0]       rem_reg;
    logic [DENW-1:0]     den_reg;
    logic [DW-1:0]       quo_reg;

    logic [DENW:0]       rem_sh;
    logic                rem_ge;

    // restoring divide step
    assign rem_sh = {rem_reg[DENW-1:0], quo_reg[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= op;
                cnt_reg  <= (op == OP_MUL) ? CW'(MW - 1) : CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= opa;
            mplier_reg <= opb;
            rem_reg    <= '0;
            den_reg    <= opb[DENW-1:0];
            quo_reg    <= opa[DW-1:0];
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            else
            begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg <= {quo_reg[DW-2:0], rem_ge};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg : AW'(quo_reg);

endmodule
`default_nettype wire

@@ design/position_line_parser_tracker.sv @@
`default_nettype none
// Position line parser and tracker.
// in_ch carries one received character (rx_byte) with its receive time now_ms.
// Characters build lines ended by CR or LF; each line "B,seq,cam,pos,valid"
// produces one event word on out_ch carrying the event kind and the tracker
// state after the update. An empty line gives no word; an overlong line
// gives an overflow word and restarts.
// An ordinary character is taken while idle. A line end goes to a check,
// then straight to emit for a rejected, duplicate, flagged-invalid or first
// frame; a filter update first runs three shift-add products and one
// restoring divide, each started and awaited until done, all on one shared
// multiply/divide unit. in_ch is not ready while a line end is being
// worked on. The event word sits in an output register, so the next line's
// characters are taken while it waits; a second event waits until the first
// is taken. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, which the block does not enforce.
// Reset clears all tracker state and loads the register defaults.
module position_line_parser_tracker
    import plt_pkg::*;
#(
    parameter int LINE_CHARS    = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    plt_in_if.sink     in_ch,
    plt_out_if.source  out_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int LW = $clog2(LINE_CHARS);
    localparam logic [LW-1:0] LEN_LAST = LW'(LINE_CHARS - 1);

    plt_state_t state_reg, state_next;

    // registers
    logic [16:0] pos_gain_reg;
    logic [16:0] vel_gain_reg;
    logic [14:0] pos_limit_reg;
    logic [15:0] ivl_min_reg;
    logic [15:0] ivl_max_reg;

    // tracker state
    logic [LW-1:0]      len_reg;
    logic               have_reg;
    logic [31:0]        last_seq_reg;
    logic [31:0]        last_cam_reg;
    logic [31:0]        last_rcv_reg;
    logic signed [15:0] raw_pos_reg;
    logic               vflag_reg;
    logic signed [31:0] fpos_reg;
    logic signed [63:0] vel_reg;
    logic [15:0]        ivl_reg;
    logic [31:0]        good_reg;
    logic [31:0]        bad_reg;

    // work registers
    plt_event_t         kind_reg;
    logic [31:0]        now_reg;
    logic [15:0]        dt_reg;
    logic               rneg_reg;
    logic signed [AW-1:0] tmp_reg;

    // output word
    logic               out_valid_reg;
    plt_event_t         o_kind_reg;
    logic [31:0]        o_seq_reg;
    logic [31:0]        o_cam_reg;
    logic signed [15:0] o_raw_reg;
    logic               o_vflag_reg;
    logic signed [31:0] o_fpos_reg;
    logic signed [63:0] o_vel_reg;
    logic [15:0]        o_ivl_reg;
    logic [31:0]        o_good_reg;
    logic [31:0]        o_bad_reg;

    // control
    logic                 in_ready;
    logic                 out_load;
    logic                 alu_start;
    plt_op_t              alu_op;
    logic signed [AW-1:0] alu_opa;
    logic [MW-1:0]        alu_opb;
    logic                 alu_busy;
    logic                 alu_done;
    logic signed [AW-1:0] alu_res;
    logic signed [AW-1:0] alu_shr;

    logic        in_fire;
    logic        is_term;
    logic        byte_en;
    plt_line_t   pl;

    logic               line_bad;
    logic               is_dup;
    logic [31:0]        cdt;
    logic [31:0]        rdt;
    logic               cdt_ok;
    logic               rdt_ok;
    logic [15:0]        dt_sel;
    logic signed [15:0] pos_val;
    logic signed [AW-1:0] target;
    logic signed [AW-1:0] fpos_ext;
    logic signed [AW-1:0] vel_ext;
    logic signed [AW-1:0] p_sum;
    logic [31:0]        p_new;
    logic signed [AW-1:0] p_new_ext;
    logic signed [AW-1:0] rate;
    logic signed [AW-1:0] v_sum;

    assign in_fire = in_ch.valid && in_ready;
    assign is_term = (in_ch.rx_byte == CH_CR) || (in_ch.rx_byte == CH_LF);
    assign byte_en = in_fire && !is_term && (len_reg != LEN_LAST);

    plt_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (in_ch.rx_byte),
        .clear   (out_load),
        .line    (pl)
    );

    plt_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (alu_op),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .busy   (alu_busy),
        .done   (alu_done),
        .result (alu_res)
    );

    // frame checks and interval choice
    assign line_bad = !pl.ok || pl.valid_over || pl.mag_over || (pl.mag > pos_limit_reg);
    assign is_dup   = have_reg && (pl.seq == last_seq_reg);
    assign cdt      = pl.cam - last_cam_reg;
    assign rdt      = now_reg - last_rcv_reg;
    assign cdt_ok   = (cdt >= {16'b0, ivl_min_reg}) && (cdt <= {16'b0, ivl_max_reg});
    assign rdt_ok   = (rdt >= {16'b0, ivl_min_reg}) && (rdt <= {16'b0, ivl_max_reg});
    assign dt_sel   = !have_reg ? 16'd0 : cdt_ok ? cdt[15:0] : rdt_ok ? rdt[15:0] : 16'd0;

    // fixed-point operands
    assign pos_val   = pl.neg ? -$signed({1'b0, pl.mag}) : $signed({1'b0, pl.mag});
    assign target    = $signed({{(AW-16){pos_val[15]}}, pos_val}) <<< FRACTION_BITS;
    assign fpos_ext  = $signed({{(AW-32){fpos_reg[31]}}, fpos_reg});
    assign vel_ext   = $signed({{(AW-64){vel_reg[63]}}, vel_reg});
    assign alu_shr   = alu_res >>> GAIN_SHIFT;
    assign p_sum     = fpos_ext + alu_shr;
    assign p_new     = sat32(p_sum);
    assign p_new_ext = $signed({{(AW-32){p_new[31]}}, p_new});
    assign rate      = rneg_reg ? -alu_res : alu_res;
    assign v_sum     = vel_ext + alu_shr;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_term)
                    begin
                        if (len_reg != '0)
                            state_next = S_CHECK;
                    end
                    else if (len_reg == LEN_LAST)
                        state_next = S_EMIT;
                end
            end
            S_CHECK:
            begin
                if (line_bad || is_dup || !pl.valid_bit || dt_sel == 16'd0)
                    state_next = S_EMIT;
                else
                    state_next = S_MUL_P;
            end
            S_MUL_P:  state_next = S_WAIT_P;
            S_WAIT_P: state_next = alu_done ? S_MUL_K : S_WAIT_P;
            S_MUL_K:  state_next = S_WAIT_K;
            S_WAIT_K: state_next = alu_done ? S_DIV : S_WAIT_K;
            S_DIV:    state_next = S_WAIT_D;
            S_WAIT_D: state_next = alu_done ? S_MUL_V : S_WAIT_D;
            S_MUL_V:  state_next = S_WAIT_V;
            S_WAIT_V: state_next = alu_done ? S_EMIT : S_WAIT_V;
            S_EMIT:   state_next = out_load ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        alu_start = 1'b0;
        alu_op    = OP_MUL;
        alu_opa   = tmp_reg;
        alu_opb   = pos_gain_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_MUL_P:
            begin
                alu_start = 1'b1;
                alu_opa   = target - fpos_ext;
                alu_opb   = pos_gain_reg;
            end
            S_MUL_K:
            begin
                alu_start = 1'b1;
                alu_opb   = RATE_SCALE;
            end
            S_DIV:
            begin
                alu_start = 1'b1;
                alu_op    = OP_DIV;
                alu_opb   = {1'b0, dt_reg};
            end
            S_MUL_V:
            begin
                alu_start = 1'b1;
                alu_opb   = vel_gain_reg;
            end
            S_EMIT:
            begin
                out_load = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg  <= 17'd16384;
            vel_gain_reg  <= 17'd16384;
            pos_limit_reg <= 15'd200;
            ivl_min_reg   <= 16'd5;
            ivl_max_reg   <= 16'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POS_GAIN:  pos_gain_reg  <= cfg_data;
                CFG_VEL_GAIN:  vel_gain_reg  <= cfg_data;
                CFG_POS_LIMIT: pos_limit_reg <= cfg_data[14:0];
                CFG_IVL_MIN:   ivl_min_reg   <= cfg_data[15:0];
                CFG_IVL_MAX:   ivl_max_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // tracker update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            have_reg     <= 1'b0;
            last_seq_reg <= '0;
            last_cam_reg <= '0;
            last_rcv_reg <= '0;
            raw_pos_reg  <= '0;
            vflag_reg    <= 1'b0;
            fpos_reg     <= '0;
            vel_reg      <= '0;
            ivl_reg      <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
            kind_reg     <= EV_VALID;
            now_reg      <= '0;
            dt_reg       <= '0;
            rneg_reg     <= 1'b0;
            tmp_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        now_reg <= in_ch.now_ms;
                        if (is_term)
                            len_reg <= '0;
                        else if (len_reg == LEN_LAST)
                        begin
                            len_reg  <= '0;
                            bad_reg  <= bad_reg + 32'd1;
                            kind_reg <= EV_OVERFLOW;
                        end
                        else
                            len_reg <= len_reg + 1'b1;
                    end
                end
                S_CHECK:
                begin
                    dt_reg <= dt_sel;
                    if (line_bad)
                    begin
                        kind_reg <= EV_MALFORMED;
                        bad_reg  <= bad_reg + 32'd1;
                    end
                    else if (is_dup)
                        kind_reg <= EV_DUPLICATE;
                    else
                    begin
                        last_seq_reg <= pl.seq;
                        last_cam_reg <= pl.cam;
                        last_rcv_reg <= now_reg;
                        raw_pos_reg  <= pos_val;
                        vflag_reg    <= pl.valid_bit;
                        have_reg     <= 1'b1;
                        if (!pl.valid_bit)
                        begin
                            kind_reg <= EV_INVALID;
                            bad_reg  <= bad_reg + 32'd1;
                        end
                        else
                        begin
                            kind_reg <= EV_VALID;
                            good_reg <= good_reg + 32'd1;
                            ivl_reg  <= dt_sel;
                            if (dt_sel == 16'd0)
                            begin
                                // no usable interval: load the filter directly
                                fpos_reg <= $signed(sat32(target));
                                vel_reg  <= '0;
                            end
                        end
                    end
                end
                S_WAIT_P:
                begin
                    if (alu_done)
                    begin
                        fpos_reg <= $signed(p_new);
                        tmp_reg  <= p_new_ext - fpos_ext;
                    end
                end
                S_WAIT_K:
                begin
                    // divide works on the magnitude
                    if (alu_done)
                    begin
                        rneg_reg <= alu_res[AW-1];
                        tmp_reg  <= alu_res[AW-1] ? -alu_res : alu_res;
                    end
                end
                S_WAIT_D:
                begin
                    if (alu_done)
                        tmp_reg <= clamp46(rate - vel_ext);
                end
                S_WAIT_V:
                begin
                    if (alu_done)
                        vel_reg <= $signed(sat64(v_sum));
                end
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_kind_reg  <= kind_reg;
            o_seq_reg   <= last_seq_reg;
            o_cam_reg   <= last_cam_reg;
            o_raw_reg   <= raw_pos_reg;
            o_vflag_reg <= vflag_reg;
            o_fpos_reg  <= fpos_reg;
            o_vel_reg   <= vel_reg;
            o_ivl_reg   <= ivl_reg;
            o_good_reg  <= good_reg;
            o_bad_reg   <= bad_reg;
        end
    end

    assign in_ch.ready                  = in_ready;
    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.event_kind            = o_kind_reg;
    assign out_ch.frame_sequence        = o_seq_reg;
    assign out_ch.camera_time_ms        = o_cam_reg;
    assign out_ch.raw_position_mm       = o_raw_reg;
    assign out_ch.frame_valid           = o_vflag_reg;
    assign out_ch.filtered_position_q16 = o_fpos_reg;
    assign out_ch.velocity_q16          = o_vel_reg;
    assign out_ch.sample_interval_ms    = o_ivl_reg;
    assign out_ch.good_count            = o_good_reg;
    assign out_ch.bad_count             = o_bad_reg;

    // the shared unit is never restarted while it runs
    a_alu_start: assert property (@(posedge clk) disable iff (!rst_n)
        alu_start |-> !alu_busy)
        else $error("arithmetic unit started while busy");

    // a non-empty line end holds off input on the next cycle
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_term && len_reg != '0) |=> !in_ch.ready)
        else $error("input taken during line end processing");

    // good count only ever steps by one
    a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
        (good_reg != $past(good_reg)) |-> (good_reg == $past(good_reg) + 32'd1))
        else $error("good count jumped");

    // a word is only loaded while the previous one is gone or leaving
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> out_ch.ready)
        else $error("event word overwritten");

endmodule
`default_nettype wire

@@ tb/position_line_parser_tracker_tb.sv @@
`default_nettype none

// one event word as the tracker reports it
typedef struct {
    plt_pkg::plt_event_t kind;
    bit [31:0] seq;
    bit [31:0] cam;
    bit [15:0] raw;
    bit        fvalid;
    bit [31:0] fpos;
    bit [63:0] vel;
    bit [15:0] ivl;
    bit [31:0] good;
    bit [31:0] bad;
} plt_word_t;

// tracker predictor and event word checker
class track_board;
    // registers
    bit [16:0] pos_gain;
    bit [16:0] vel_gain;
    bit [14:0] pos_limit;
    bit [15:0] ivl_min;
    bit [15:0] ivl_max;
    // tracker state
    byte unsigned line_buf[63];
    int        line_len;
    bit        have_frame;
    bit [31:0] seq_last;
    bit [31:0] cam_last;
    bit [31:0] rcv_last;
    int        raw_last;
    bit        flag_last;
    int        pos_q16;
    longint    vel_q16;
    bit [15:0] ivl_last;
    bit [31:0] good_n;
    bit [31:0] bad_n;
    plt_word_t pending_events[$];
    int        errors;

    function new();
        pos_gain = 17'd16384;
        vel_gain = 17'd16384;
        pos_limit = 15'd200;
        ivl_min = 16'd5;
        ivl_max = 16'd200;
        line_len = 0;
        have_frame = 0;
        seq_last = 0;
        cam_last = 0;
        rcv_last = 0;
        raw_last = 0;
        flag_last = 0;
        pos_q16 = 0;
        vel_q16 = 0;
        ivl_last = 0;
        good_n = 0;
        bad_n = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] data);
        case (idx)
            plt_pkg::CFG_POS_GAIN:  pos_gain = data;
            plt_pkg::CFG_VEL_GAIN:  vel_gain = data;
            plt_pkg::CFG_POS_LIMIT: pos_limit = data[14:0];
            plt_pkg::CFG_IVL_MIN:   ivl_min = data[15:0];
            plt_pkg::CFG_IVL_MAX:   ivl_max = data[15:0];
            default: ;
        endcase
    endfunction

    function bit take_char(inout int at, input byte unsigned c);
        if (at < line_len && line_buf[at] == c)
        begin
            at++;
            return 1;
        end
        return 0;
    endfunction

    // 1 to 10 decimal digits
    function bit take_num(inout int at, output longint unsigned v);
        int n;
        n = 0;
        v = 0;
        while (at < line_len && line_buf[at] >= plt_pkg::CH_0 && line_buf[at] <= plt_pkg::CH_9)
        begin
            if (n == plt_pkg::MAX_DIGITS)
                return 0;
            v = v * 10 + (line_buf[at] - plt_pkg::CH_0);
            n++;
            at++;
        end
        return n > 0;
    endfunction

    function bit in_window(bit [31:0] d);
        return d >= ivl_min && d <= ivl_max;
    endfunction

    function longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // parse the stored line and update the tracker
    function plt_pkg::plt_event_t parse_frame(bit [31:0] now);
        int at;
        longint unsigned seqv, camv, magv, valv;
        bit neg;
        int pos;
        bit [31:0] dt, cdt, rdt;
        longint prev, target, nxt, rate;
        logic signed [65:0] diff, gain, step, sum;
        at = 0;
        neg = 0;
        dt = 0;
        if (!take_char(at, plt_pkg::CH_B) || !take_char(at, plt_pkg::CH_COMMA))
            return plt_pkg::EV_MALFORMED;
        if (!take_num(at, seqv) || seqv > 64'hFFFF_FFFF)
            return plt_pkg::EV_MALFORMED;
        if (!take_char(at, plt_pkg::CH_COMMA))
            return plt_pkg::EV_MALFORMED;
        if (!take_num(at, camv) || camv > 64'hFFFF_FFFF)
            return plt_pkg::EV_MALFORMED;
        if (!take_char(at, plt_pkg::CH_COMMA))
            return plt_pkg::EV_MALFORMED;
        if (take_char(at, plt_pkg::CH_MINUS))
            neg = 1;
        else
            void'(take_char(at, plt_pkg::CH_PLUS));
        if (!take_num(at, magv))
            return plt_pkg::EV_MALFORMED;
        if (!take_char(at, plt_pkg::CH_COMMA))
            return plt_pkg::EV_MALFORMED;
        if (!take_num(at, valv))
            return plt_pkg::EV_MALFORMED;
        if (valv > 1 || magv > pos_limit)
            return plt_pkg::EV_MALFORMED;
        pos = neg ? -int'(magv) : int'(magv);
        if (have_frame && seqv[31:0] == seq_last)
            return plt_pkg::EV_DUPLICATE;
        if (have_frame)
        begin
            cdt = camv[31:0] - cam_last;
            rdt = now - rcv_last;
            if (in_window(cdt))
                dt = cdt;
            else if (in_window(rdt))
                dt = rdt;
        end
        seq_last = seqv[31:0];
        cam_last = camv[31:0];
        rcv_last = now;
        raw_last = pos;
        flag_last = valv[0];
        if (valv == 0)
        begin
            have_frame = 1;
            bad_n++;
            return plt_pkg::EV_INVALID;
        end
        if (!have_frame || dt == 0)
        begin
            pos_q16 = int'(clip32(longint'(pos) <<< 16));
            vel_q16 = 0;
            ivl_last = 0;
        end
        else
        begin
            prev = pos_q16;
            target = longint'(pos) <<< 16;
            nxt = clip32(prev + ((longint'(pos_gain) * (target - prev)) >>> 16));
            rate = (nxt - prev) * 1000 / longint'(dt);
            diff = rate;
            diff = diff - vel_q16;
            if (diff > (66'sd1 <<< 46))
                diff = 66'sd1 <<< 46;
            if (diff < -(66'sd1 <<< 46))
                diff = -(66'sd1 <<< 46);
            gain = vel_gain;
            step = (gain * diff) >>> 16;
            sum = vel_q16;
            sum = sum + step;
            if (sum > 66'sh0_7FFF_FFFF_FFFF_FFFF)
                vel_q16 = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (sum < -66'sh0_8000_0000_0000_0000)
                vel_q16 = 64'sh8000_0000_0000_0000;
            else
                vel_q16 = sum[63:0];
            pos_q16 = int'(nxt);
            ivl_last = dt[15:0];
        end
        have_frame = 1;
        good_n++;
        return plt_pkg::EV_VALID;
    endfunction

    function void push_word(plt_pkg::plt_event_t kind);
        plt_word_t w;
        w.kind = kind;
        w.seq = seq_last;
        w.cam = cam_last;
        w.raw = raw_last[15:0];
        w.fvalid = flag_last;
        w.fpos = pos_q16;
        w.vel = vel_q16;
        w.ivl = ivl_last;
        w.good = good_n;
        w.bad = bad_n;
        pending_events.push_back(w);
    endfunction

    // note one accepted character
    function void take_byte(byte unsigned c, bit [31:0] now);
        plt_pkg::plt_event_t kind;
        if (c == plt_pkg::CH_LF || c == plt_pkg::CH_CR)
        begin
            if (line_len == 0)
                return;
            kind = parse_frame(now);
            if (kind == plt_pkg::EV_MALFORMED)
                bad_n++;
            line_len = 0;
            push_word(kind);
        end
        else if (line_len < 63)
        begin
            line_buf[line_len] = c;
            line_len++;
        end
        else
        begin
            line_len = 0;
            bad_n++;
            push_word(plt_pkg::EV_OVERFLOW);
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task cmp(string name, bit [63:0] got, bit [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // compare one accepted event word with the oldest prediction
    task check(plt_word_t got);
        plt_word_t w;
        if (pending_events.size() == 0)
        begin
            report("event word with nothing pending");
            return;
        end
        w = pending_events.pop_front();
        cmp("event_kind", got.kind, w.kind);
        cmp("frame_sequence", got.seq, w.seq);
        cmp("camera_time_ms", got.cam, w.cam);
        cmp("raw_position_mm", got.raw, w.raw);
        cmp("frame_valid", got.fvalid, w.fvalid);
        cmp("filtered_position_q16", got.fpos, w.fpos);
        cmp("velocity_q16", got.vel, w.vel);
        cmp("sample_interval_ms", got.ivl, w.ivl);
        cmp("good_count", got.good, w.good);
        cmp("bad_count", got.bad, w.bad);
    endtask
endclass

module position_line_parser_tracker_tb;
    import plt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    plt_in_if  in_ch();
    plt_out_if out_ch();

    position_line_parser_tracker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    track_board board;
    bit         calm;
    int         stall_req;
    int         cycles;
    int         word_count;
    bit [31:0]  now_cur;
    bit [31:0]  seq_cur;
    bit [31:0]  cam_cur;
    int         byte_count;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: check words, random stalls, long hold-off on request
    initial
    begin
        int hold;
        plt_word_t got;
        hold = 0;
        out_ch.ready <= 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready && rst_n)
            begin
                got.kind = plt_event_t'(out_ch.event_kind);
                got.seq = out_ch.frame_sequence;
                got.cam = out_ch.camera_time_ms;
                got.raw = out_ch.raw_position_mm;
                got.fvalid = out_ch.frame_valid;
                got.fpos = out_ch.filtered_position_q16;
                got.vel = out_ch.velocity_q16;
                got.ivl = out_ch.sample_interval_ms;
                got.good = out_ch.good_count;
                got.bad = out_ch.bad_count;
                board.check(got);
                word_count++;
            end
            if (stall_req > 0)
            begin
                hold = stall_req;
                stall_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // send one character, at times with a random gap ahead of it
    task send_byte(byte unsigned c);
        if (!calm && $urandom_range(99) < 10)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.rx_byte <= c;
        in_ch.now_ms <= now_cur;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.take_byte(c, now_cur);
        byte_count++;
    endtask

    task send_line(string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    task end_line();
        case ($urandom_range(2))
            0: send_byte(CH_LF);
            1: send_byte(CH_CR);
            default:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        endcase
    endtask

    // wait for all pending words, then let the block settle
    task drain();
        in_ch.valid <= 0;
        while (board.pending_events.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task write_regs(int pg, int vg, int lim, int lo, int hi);
        int vals[5];
        vals = '{pg, vg, lim, lo, hi};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_data <= 17'(vals[i]);
            @(posedge clk);
            board.write_reg(3'(i), 17'(vals[i]));
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // one random line: mostly well-formed frames, some noise
    task random_line();
        int r, mag, span;
        string s;
        r = $urandom_range(99);
        now_cur += (r < 4) ? $urandom() : $urandom_range(1, 260);
        if (r < 85)
        begin
            r = $urandom_range(99);
            if (r < 8)
                ;
            else if (r < 12)
                seq_cur = $urandom();
            else
                seq_cur++;
            r = $urandom_range(99);
            cam_cur += (r < 5) ? $urandom() : $urandom_range(0, 260);
            span = board.pos_limit + 3;
            if (span > 99999)
                span = 99999;
            mag = $urandom_range(0, span);
            s = $sformatf("B,%s%0d,%0d,", ($urandom_range(9) == 0) ? "00" : "",
                          seq_cur, cam_cur);
            r = $urandom_range(2);
            if (r == 0)
                s = {s, "-"};
            else if (r == 1 && $urandom_range(1))
                s = {s, "+"};
            r = $urandom_range(99);
            s = {s, $sformatf("%0d,%0d", mag, (r < 84) ? 1 : (r < 96) ? 0 :
                 $urandom_range(2, 9))};
            if ($urandom_range(19) == 0)
                s = {s, ",x"};
            if ($urandom_range(19) == 0)
                s = s.substr(0, $urandom_range(0, s.len() - 2));
            send_line(s);
        end
        else if (r < 95)
        begin
            // random bytes of any value
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom_range(255)));
        end
        else
        begin
            // overlong line
            repeat ($urandom_range(63, 80))
                send_byte(8'(8'h30 + $urandom_range(9)));
        end
        end_line();
    endtask

    task random_phase(int nbytes, int nwords);
        int b0, w0;
        b0 = byte_count;
        w0 = word_count;
        while (byte_count - b0 < nbytes || word_count - w0 < nwords)
            random_line();
    endtask

    initial
    begin
        board = new();
        calm = 0;
        stall_req = 0;
        cycles = 0;
        word_count = 0;
        byte_count = 0;
        now_cur = 32'd1000;
        seq_cur = 100;
        cam_cur = 5000;
        rst_n <= 0;
        cfg_we <= 0;
        cfg_index <= CFG_POS_GAIN;
        cfg_data <= 0;
        in_ch.valid <= 0;
        in_ch.rx_byte <= 0;
        in_ch.now_ms <= 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed lines at the reset settings
        send_line("B,1,1000,0,1\n");
        now_cur += 10;
        send_line("B,2,1010,100,1\r");
        send_line("B,2,1020,5,1\n");
        now_cur += 10;
        send_line("B,3,1030,200,1\n");
        now_cur += 10;
        send_line("B,4,1040,-200,1\n");
        send_line("B,5,1050,201,1\n");
        send_line("B,6,1060,+7,0\n");
        send_line("B,7,1070,7,2\n");
        now_cur += 20;
        send_line("B,4294967295,1080,3,1\n");
        send_line("B,4294967296,1090,3,1\n");
        send_line("B,12345678901,1,1,1\n");
        now_cur += 50;
        send_line("B,8,4294967295,3,1\n");
        send_line("\r\n");
        send_line("B,9,,3,1\n");
        send_line("b,9,1,1,1\n");
        send_line("B, 12,1,1,1\n");
        now_cur += 30;
        send_line("B,10,0000000001,1,1junk\n");
        send_line("B,");
        repeat (70) send_byte("1");
        send_byte(CH_LF);
        now_cur += 40;
        send_line("B,11,900000,-1,1\n");
        drain();

        // gains at one, widest limit and window; long receiver hold-off
        write_regs(65536, 65536, 32767, 0, 65535);
        random_phase(40, 2);
        stall_req = 3000;
        random_phase(80, 4);
        drain();

        // gains at zero, zero limit, empty window
        write_regs(0, 0, 0, 65535, 0);
        random_phase(80, 4);
        drain();

        // random gains, no idling on either side
        calm = 1;
        write_regs($urandom_range(65536), $urandom_range(65536), 1000, 1, 300);
        random_phase(100, 5);
        calm = 0;
        drain();

        write_regs(16384, 100, 200, 5, 200);
        random_phase(100, 5);
        drain();

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

@@ position_line_parser_tracker.f @@
design/plt_pkg.sv
design/plt_if.sv
design/plt_parser.sv
design/plt_muldiv.sv
design/position_line_parser_tracker.sv
tb/position_line_parser_tracker_tb.sv
